@@ rtl/cprg_pkg.sv @@
// Shared types, constants and rounding helper for the camera pixel ray generator.
`default_nettype none
package cprg_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int NORM_EXTRA = 5;
  localparam logic [12:0] MAX_IMG = 13'd4096;

  localparam int DIV_QB  = 23;
  localparam int QW      = DIV_QB + 1;
  localparam int DIV_NW  = 56;
  localparam int DIV_DW  = 38;
  localparam int DIV_LAT = DIV_QB + 2;
  localparam logic [QW-1:0] SAT_LIMIT = {1'b0, {DIV_QB{1'b1}}};

  localparam int ISQ_STEPS = 31;
  localparam int ISQ_W     = 2 * ISQ_STEPS;

  localparam int SWP_PRE = 8;
  localparam int SWP_LAT = SWP_PRE + DIV_LAT;
  localparam int NRM_PRE = 3;
  localparam int NRM_LAT = NRM_PRE + ISQ_STEPS + DIV_LAT;

  localparam logic signed [15:0] DIR_ONE = 16'sd16384;

  typedef enum logic [2:0] {
    REG_EYE, REG_VIEW, REG_TOP, REG_HOR, REG_HTRIG, REG_VTRIG, REG_WIDTH, REG_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic signed [19:0] origin_x;
    logic signed [19:0] origin_y;
    logic signed [19:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               out_of_bounds;
  } ray_t;

  typedef struct packed {
    logic vld;
    logic oob;
  } side_t;

  typedef logic signed [QW-1:0] quo_t;

  // Drops FRAC_BITS fraction bits, rounding half away from zero.
  function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] r;
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

@@ rtl/cprg_div.sv @@
// Pipelined rounding, saturating signed divider, one quotient bit per stage.
`default_nettype none
module cprg_div (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [cprg_pkg::DIV_NW-1:0] num_i,
  input  logic signed [cprg_pkg::DIV_DW-1:0] den_i,
  output logic signed [cprg_pkg::QW-1:0]     quo_o
);
  import cprg_pkg::*;

  localparam int RW  = DIV_DW + 1 + DIV_QB;
  localparam int NST = DIV_QB + 2;

  typedef struct packed {
    logic [RW-1:0]     rem;
    logic [DIV_DW:0]   d2;
    logic [DIV_QB-1:0] q;
    logic              sat;
    logic              neg;
    logic              zero;
  } dstg_t;

  dstg_t st_r   [NST];
  dstg_t st_nxt [NST];
  logic [DIV_NW-1:0] mn;
  logic [DIV_DW-1:0] md;
  logic [RW-1:0]     trial;
  logic [QW-1:0]     mag;

  always_comb begin
    mn = num_i[DIV_NW-1] ? DIV_NW'(-num_i) : DIV_NW'(num_i);
    md = den_i[DIV_DW-1] ? DIV_DW'(-den_i) : DIV_DW'(den_i);
    st_nxt[0].rem  = RW'({mn, 1'b0}) + RW'(md);
    st_nxt[0].d2   = {md, 1'b0};
    st_nxt[0].q    = '0;
    st_nxt[0].sat  = 1'b0;
    st_nxt[0].neg  = num_i[DIV_NW-1] ^ den_i[DIV_DW-1];
    st_nxt[0].zero = (num_i == '0);
    st_nxt[1]     = st_r[0];
    st_nxt[1].sat = (st_r[0].rem >= {st_r[0].d2, {DIV_QB{1'b0}}});
    trial = '0;
    for (int j = 2; j < NST; j++) begin
      st_nxt[j] = st_r[j-1];
      trial = RW'(st_r[j-1].d2) << (NST - 1 - j);
      if (st_r[j-1].rem >= trial) begin
        st_nxt[j].rem = st_r[j-1].rem - trial;
        st_nxt[j].q[NST-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    mag = st_r[NST-1].sat ? SAT_LIMIT : {1'b0, st_r[NST-1].q};
    if (st_r[NST-1].zero) begin
      quo_o = '0;
    end else if (st_r[NST-1].neg) begin
      quo_o = -$signed(mag);
    end else begin
      quo_o = $signed(mag);
    end
  end

endmodule
`default_nettype wire

@@ rtl/cprg_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module cprg_isqrt (
  input  logic                               clk,
  input  logic                               adv,
  input  logic [cprg_pkg::ISQ_W-1:0]         v_i,
  output logic [cprg_pkg::ISQ_STEPS-1:0]     root_o
);
  import cprg_pkg::*;

  typedef struct packed {
    logic [ISQ_W-1:0] v;
    logic [ISQ_W-1:0] res;
  } sstg_t;

  sstg_t st_r   [ISQ_STEPS];
  sstg_t st_nxt [ISQ_STEPS];
  sstg_t cur;
  logic [ISQ_W-1:0] bitv;

  always_comb begin
    cur  = '0;
    bitv = '0;
    for (int j = 0; j < ISQ_STEPS; j++) begin
      if (j == 0) begin
        cur.v   = v_i;
        cur.res = '0;
      end else begin
        cur = st_r[j-1];
      end
      bitv = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
      if (cur.v >= cur.res + bitv) begin
        st_nxt[j].v   = cur.v - (cur.res + bitv);
        st_nxt[j].res = (cur.res >> 1) + bitv;
      end else begin
        st_nxt[j].v   = cur.v;
        st_nxt[j].res = cur.res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign root_o = st_r[ISQ_STEPS-1].res[ISQ_STEPS-1:0];

endmodule
`default_nettype wire

@@ rtl/cprg_sweep.sv @@
// Boundary vector sweep: builds, scales and divides one swept boundary vector.
`default_nettype none
module cprg_sweep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  cprg_pkg::side_t       side_i,
  input  logic [11:0]           pos_i,
  input  logic [12:0]           size_i,
  input  logic [31:0]           trig_i,
  input  logic [47:0]           vw_i,
  input  logic [47:0]           xd_i,
  input  logic                  neg_i,
  output cprg_pkg::side_t       side_o,
  output cprg_pkg::quo_t        p_o [3]
);
  import cprg_pkg::*;

  side_t side_r [SWP_LAT];

  logic signed [31:0] pc1_r [3];
  logic signed [31:0] ps1_r [3];
  logic [11:0]        pos1_r, pos2_r, pos3_r, pos4_r, pos5_r, pos6_r;
  logic signed [19:0] b2_r [3];
  logic signed [19:0] b3_r [3];
  logic signed [19:0] b4_r [3];
  logic signed [19:0] b5_r [3];
  logic signed [35:0] bv3_r [3];
  logic signed [23:0] d4_r;
  logic signed [39:0] dv5_r [3];
  logic signed [37:0] dw5_r, dw6_r, dw7_r, dw8_r;
  logic signed [33:0] bw5_r [3];
  logic signed [33:0] bw6_r [3];
  logic signed [33:0] bw7_r [3];
  logic signed [26:0] df6_r [3];
  logic signed [40:0] pr7_r [3];
  logic signed [41:0] num8_r [3];
  logic signed [13:0] size_s;

  assign size_s = $signed({1'b0, size_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SWP_LAT; i++) begin
        side_r[i] <= '0;
      end
    end else if (adv) begin
      side_r[0] <= side_i;
      for (int i = 1; i < SWP_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos1_r <= pos_i;
      pos2_r <= pos1_r;
      pos3_r <= pos2_r;
      pos4_r <= pos3_r;
      pos5_r <= pos4_r;
      pos6_r <= pos5_r;
      d4_r   <= 24'(rnd_frac(64'(bv3_r[0]) + 64'(bv3_r[1]) + 64'(bv3_r[2])));
      dw5_r  <= d4_r * size_s;
      dw6_r  <= dw5_r;
      dw7_r  <= dw6_r;
      dw8_r  <= dw7_r;
      for (int i = 0; i < 3; i++) begin
        pc1_r[i]  <= $signed(trig_i[15:0]) * $signed(vw_i[16*i +: 16]);
        ps1_r[i]  <= $signed(trig_i[31:16]) * $signed(xd_i[16*i +: 16]);
        b2_r[i]   <= neg_i ? 20'(rnd_frac(64'(pc1_r[i]) - 64'(ps1_r[i])))
                           : 20'(rnd_frac(64'(pc1_r[i]) + 64'(ps1_r[i])));
        bv3_r[i]  <= b2_r[i] * $signed(vw_i[16*i +: 16]);
        b3_r[i]   <= b2_r[i];
        b4_r[i]   <= b3_r[i];
        dv5_r[i]  <= d4_r * $signed(vw_i[16*i +: 16]);
        bw5_r[i]  <= b4_r[i] * size_s;
        b5_r[i]   <= b4_r[i];
        df6_r[i]  <= 27'(rnd_frac(64'(dv5_r[i])) - 64'(b5_r[i]));
        bw6_r[i]  <= bw5_r[i];
        pr7_r[i]  <= df6_r[i] * $signed({1'b0, pos6_r, 1'b0});
        bw7_r[i]  <= bw6_r[i];
        num8_r[i] <= 42'(pr7_r[i]) + 42'(bw7_r[i]);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    cprg_div u_div (
      .clk   (clk),
      .adv   (adv),
      .num_i ($signed({num8_r[g], {FRAC_BITS{1'b0}}})),
      .den_i (dw8_r),
      .quo_o (p_o[g])
    );
  end

  assign side_o = side_r[SWP_LAT-1];

endmodule
`default_nettype wire

@@ rtl/cprg_norm.sv @@
// Direction sum and normalization: length, square root and per-axis division.
`default_nettype none
module cprg_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  cprg_pkg::side_t    side_i,
  input  cprg_pkg::quo_t     ph_i [3],
  input  cprg_pkg::quo_t     pv_i [3],
  input  logic [47:0]        vw_i,
  output cprg_pkg::side_t    side_o,
  output logic signed [15:0] dir_o [3]
);
  import cprg_pkg::*;

  localparam int SVL = NRM_PRE + ISQ_STEPS;

  typedef struct packed {
    logic vld;
    logic oob;
    logic zero;
  } nside_t;

  nside_t             side_r [NRM_LAT];
  logic signed [25:0] sv_r [SVL][3];
  logic signed [25:0] sv_nxt [3];
  logic [24:0]        mg [3];
  logic [49:0]        sq2_r [3];
  logic [ISQ_W-1:0]   len3_r;
  logic [ISQ_STEPS-1:0] root;
  quo_t               quo [3];
  nside_t             last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv_nxt[i] = 26'(ph_i[i]) + 26'(pv_i[i]) - 26'($signed(vw_i[16*i +: 16]));
      mg[i] = sv_r[0][i][25] ? 25'(-sv_r[0][i]) : 25'(sv_r[0][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NRM_LAT; i++) begin
        side_r[i] <= '0;
      end
    end else if (adv) begin
      side_r[0].vld  <= side_i.vld;
      side_r[0].oob  <= side_i.oob;
      side_r[0].zero <= (sv_nxt[0] == '0) && (sv_nxt[1] == '0) && (sv_nxt[2] == '0);
      for (int i = 1; i < NRM_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r[0] <= sv_nxt;
      for (int s = 1; s < SVL; s++) begin
        sv_r[s] <= sv_r[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= mg[i] * mg[i];
      end
      len3_r <= ISQ_W'({(52'(sq2_r[0]) + 52'(sq2_r[1]) + 52'(sq2_r[2])),
                        {(2 * NORM_EXTRA){1'b0}}});
    end
  end

  cprg_isqrt u_isqrt (
    .clk    (clk),
    .adv    (adv),
    .v_i    (len3_r),
    .root_o (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    cprg_div u_div (
      .clk   (clk),
      .adv   (adv),
      .num_i (DIV_NW'(sv_r[SVL-1][g]) <<< (FRAC_BITS + NORM_EXTRA)),
      .den_i ($signed(DIV_DW'(root))),
      .quo_o (quo[g])
    );
  end

  assign last = side_r[NRM_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (last.oob || last.zero) begin
        dir_o[i] = '0;
      end else if (quo[i] > QW'(DIR_ONE)) begin
        dir_o[i] = DIR_ONE;
      end else if (quo[i] < -QW'(DIR_ONE)) begin
        dir_o[i] = -DIR_ONE;
      end else begin
        dir_o[i] = 16'(quo[i]);
      end
    end
  end

  assign side_o.vld = last.vld;
  assign side_o.oob = last.oob;

endmodule
`default_nettype wire

@@ rtl/camera_pixel_ray_generator.sv @@
// Top level of the camera pixel ray generator: registers, pipeline and output queue.
// A pinhole camera ray generator: each pixel request yields one ray whose origin is the
// eye point and whose Q1.14 unit direction comes from sweeping the horizontal and
// vertical boundary vectors, summing them and normalizing. A new pixel is taken every
// cycle unless the input is stalled; a ray passes through one input stage, 33 stages of
// boundary sweep with a one-bit-per-stage divider and 59 stages of normalization with a
// one-bit-per-stage square root and divider. A two-entry output queue decouples the
// sides, so input is stalled only when both entries hold rays that have not been taken.
// Pixels at or beyond the configured width or height return zero direction with the
// out_of_bounds flag set. Registers sit at byte address 8*i and must only be written
// while no request is in flight.
`default_nettype none
module camera_pixel_ray_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cprg_pkg::pixel_req_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cprg_pkg::ray_t       out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import cprg_pkg::*;

  logic [59:0] eye_r;
  logic [47:0] view_r, top_r, hor_r;
  logic [31:0] htrig_r, vtrig_r;
  logic [12:0] width_r, height_r;
  logic [12:0] wc, hc;

  logic        adv;
  logic        s0_vld_r;
  logic [11:0] px_r, py_r;
  side_t       hs_in, vs_in, hs_out, vs_out, ns_in, ns_out;
  quo_t        ph [3];
  quo_t        pv [3];
  logic signed [15:0] dir [3];

  ray_t        fifo_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;
  ray_t        ray;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r    <= '0;
      view_r   <= 48'h4000_0000_0000;
      top_r    <= 48'h0000_4000_0000;
      hor_r    <= 48'h0000_0000_C000;
      htrig_r  <= 32'h2D41_2D41;
      vtrig_r  <= 32'h2D41_2D41;
      width_r  <= 13'd640;
      height_r <= 13'd480;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[5:3]))
        REG_EYE:    eye_r    <= pwdata[59:0];
        REG_VIEW:   view_r   <= pwdata[47:0];
        REG_TOP:    top_r    <= pwdata[47:0];
        REG_HOR:    hor_r    <= pwdata[47:0];
        REG_HTRIG:  htrig_r  <= pwdata[31:0];
        REG_VTRIG:  vtrig_r  <= pwdata[31:0];
        REG_WIDTH:  width_r  <= pwdata[12:0];
        REG_HEIGHT: height_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[5:3]))
      REG_EYE:    prdata = 64'(eye_r);
      REG_VIEW:   prdata = 64'(view_r);
      REG_TOP:    prdata = 64'(top_r);
      REG_HOR:    prdata = 64'(hor_r);
      REG_HTRIG:  prdata = 64'(htrig_r);
      REG_VTRIG:  prdata = 64'(vtrig_r);
      REG_WIDTH:  prdata = 64'(width_r);
      REG_HEIGHT: prdata = 64'(height_r);
      default:    prdata = '0;
    endcase
  end

  assign wc = (width_r > MAX_IMG) ? MAX_IMG : width_r;
  assign hc = (height_r > MAX_IMG) ? MAX_IMG : height_r;

  assign adv      = (cnt_r != 2'd2);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= in_data.pixel_x;
      py_r <= in_data.pixel_y;
    end
  end

  assign hs_in.vld = s0_vld_r;
  assign hs_in.oob = ({1'b0, px_r} >= width_r);
  assign vs_in.vld = s0_vld_r;
  assign vs_in.oob = ({1'b0, py_r} >= height_r);

  cprg_sweep u_sweep_h (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (hs_in),
    .pos_i  (px_r),
    .size_i (wc),
    .trig_i (htrig_r),
    .vw_i   (view_r),
    .xd_i   (hor_r),
    .neg_i  (1'b1),
    .side_o (hs_out),
    .p_o    (ph)
  );

  cprg_sweep u_sweep_v (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (vs_in),
    .pos_i  (py_r),
    .size_i (hc),
    .trig_i (vtrig_r),
    .vw_i   (view_r),
    .xd_i   (top_r),
    .neg_i  (1'b0),
    .side_o (vs_out),
    .p_o    (pv)
  );

  assign ns_in.vld = hs_out.vld & vs_out.vld;
  assign ns_in.oob = hs_out.oob | vs_out.oob;

  cprg_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (ns_in),
    .ph_i   (ph),
    .pv_i   (pv),
    .vw_i   (view_r),
    .side_o (ns_out),
    .dir_o  (dir)
  );

  always_comb begin
    ray.origin_x      = $signed(eye_r[19:0]);
    ray.origin_y      = $signed(eye_r[39:20]);
    ray.origin_z      = $signed(eye_r[59:40]);
    ray.dir_x         = dir[0];
    ray.dir_y         = dir[1];
    ray.dir_z         = dir[2];
    ray.out_of_bounds = ns_out.oob;
  end

  assign push = adv && ns_out.vld;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= ray;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = fifo_r[rp_r];

endmodule
`default_nettype wire

@@ rtl/cprg_checker.sv @@
// Port-level checks for the camera pixel ray generator and their binding.
`default_nettype none
module cprg_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input cprg_pkg::ray_t out_data
);
  import cprg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_bounds |->
      out_data.dir_x == '0 && out_data.dir_y == '0 && out_data.dir_z == '0)
    else $error("out of bounds ray carries a direction");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.dir_x >= -DIR_ONE && out_data.dir_x <= DIR_ONE &&
      out_data.dir_y >= -DIR_ONE && out_data.dir_y <= DIR_ONE &&
      out_data.dir_z >= -DIR_ONE && out_data.dir_z <= DIR_ONE)
    else $error("direction component beyond unit range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while no result is waiting");

endmodule

bind camera_pixel_ray_generator cprg_checker u_cprg_checker (.*);
`default_nettype wire
